// ===== rtl/sts_pkg.sv =====
// types, token kind codes, scanner mode codes and decode functions for the
// script token scanner; used by the front, queue, back and top rtl files
`default_nettype none

package sts_pkg;

   localparam int NEST_DEPTH = 8;
   localparam int KW_BYTES   = 8;
   localparam int LVL_W      = $clog2(NEST_DEPTH + 1);
   localparam int IDX_W      = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int KW_IDX_W   = $clog2(KW_BYTES);
   localparam int KW_COUNT   = 15;
   localparam int MAX_RES    = 3;

   localparam logic [23:0] LINE_MAX = 24'hFF_FFFF;
   localparam logic [15:0] U16_MAX  = 16'hFFFF;
   localparam logic [62:0] INT_MAX  = 63'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [7:0] OP_NONE  = 8'd255;
   localparam logic [7:0] OP_TWICE = 8'd254;

   // token kinds
   localparam logic [5:0] K_END = 6'd0,  K_ADD_SET = 6'd1, K_INC = 6'd2, K_ADD = 6'd3;
   localparam logic [5:0] K_SUB_SET = 6'd4, K_DECR = 6'd5, K_ARROW = 6'd6, K_SUB = 6'd7;
   localparam logic [5:0] K_MUL_SET = 6'd8, K_MUL = 6'd9, K_DIV_SET = 6'd10, K_DIV = 6'd11;
   localparam logic [5:0] K_POW_SET = 6'd12, K_POW = 6'd13, K_MOD_SET = 6'd14, K_MOD = 6'd15;
   localparam logic [5:0] K_EQ = 6'd16, K_FAT = 6'd17, K_ASSIGN = 6'd18, K_LE = 6'd19;
   localparam logic [5:0] K_SHL_SET = 6'd20, K_SHL = 6'd21, K_LT = 6'd22, K_GE = 6'd23;
   localparam logic [5:0] K_SHR_SET = 6'd24, K_SHR = 6'd25, K_GT = 6'd26, K_LAND = 6'd27;
   localparam logic [5:0] K_AND_SET = 6'd28, K_AND = 6'd29, K_LOR = 6'd30, K_OR_SET = 6'd31;
   localparam logic [5:0] K_OR = 6'd32, K_COALESCE = 6'd33, K_QUERY = 6'd34;
   localparam logic [5:0] K_NOT_SET = 6'd35, K_NOT = 6'd36, K_NEWLINE = 6'd37;
   localparam logic [5:0] K_LPAR = 6'd38, K_RPAR = 6'd39, K_LCURLY = 6'd40;
   localparam logic [5:0] K_RSQUARE = 6'd41, K_RCURLY = 6'd42, K_COLON = 6'd43;
   localparam logic [5:0] K_COMMA = 6'd44, K_STR = 6'd45;
   localparam logic [5:0] K_IF = 6'd46, K_LET = 6'd47, K_DECL = 6'd48, K_ELSE = 6'd49;
   localparam logic [5:0] K_THIS = 6'd50, K_TRUE = 6'd51, K_FALSE = 6'd52, K_NULL = 6'd53;
   localparam logic [5:0] K_FOR = 6'd54, K_CALL = 6'd55, K_JUMP = 6'd56, K_BREAK = 6'd57;
   localparam logic [5:0] K_WHILE = 6'd58, K_MATCHKW = 6'd59, K_RETURN = 6'd60;
   localparam logic [5:0] K_NAME = 6'd61, K_INT = 6'd62, K_REAL = 6'd63;

   // scanner modes
   localparam logic [3:0] M_IDLE = 4'd0, M_COMMENT = 4'd1, M_OP = 4'd2, M_OP2 = 4'd3;
   localparam logic [3:0] M_WORD = 4'd4, M_INT = 4'd5, M_REAL = 4'd6, M_DQ = 4'd7;
   localparam logic [3:0] M_DQ_ESC = 4'd8, M_SQ = 4'd9, M_SQ_ESC = 4'd10;
   localparam logic [3:0] M_SQ_HASH = 4'd11;

   localparam logic ITEM_TOKEN = 1'b0;
   localparam logic ITEM_BYTE  = 1'b1;

   typedef struct packed {
      logic        item_kind;
      logic [5:0]  token_kind;
      logic [23:0] line_number;
      logic [15:0] column_number;
      logic [15:0] token_length;
      logic [62:0] integer_value;
      logic [7:0]  string_byte;
   } result_type;

   typedef struct packed {
      logic [1:0]                 count;
      result_type [MAX_RES-1:0]   res;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // keyword text left justified, first character in the top byte
   localparam logic [8*KW_BYTES-1:0] KW_TEXT [2][KW_COUNT] = '{
      '{ {"if", 48'd0}, {"let", 40'd0}, {"dec", 40'd0}, {"else", 32'd0},
         {"this", 32'd0}, {"true", 32'd0}, {"false", 24'd0}, {"null", 32'd0},
         {"for", 40'd0}, {"call", 32'd0}, {"jump", 32'd0}, {"break", 24'd0},
         {"while", 24'd0}, {"match", 24'd0}, {"return", 16'd0} },
      '{ {"si", 48'd0}, {"sino", 32'd0}, {"por", 40'd0}, {"mientras"},
         {"salta", 24'd0}, {"sale", 32'd0}, {"coincide"}, {"deja", 32'd0},
         {"dec", 40'd0}, {"esto", 32'd0}, {"llama", 24'd0}, {"verdad", 16'd0},
         {"falso", 24'd0}, {"nulo", 32'd0}, {"regresa", 8'd0} } };

   localparam logic [KW_IDX_W:0] KW_LEN [2][KW_COUNT] = '{
      '{ 2, 3, 3, 4, 4, 4, 5, 4, 3, 4, 4, 5, 5, 5, 6 },
      '{ 2, 4, 3, 8, 5, 4, 8, 4, 3, 4, 5, 6, 5, 4, 7 } };

   localparam logic [5:0] KW_KIND [2][KW_COUNT] = '{
      '{ K_IF, K_LET, K_DECL, K_ELSE, K_THIS, K_TRUE, K_FALSE, K_NULL, K_FOR,
         K_CALL, K_JUMP, K_BREAK, K_WHILE, K_MATCHKW, K_RETURN },
      '{ K_IF, K_ELSE, K_FOR, K_WHILE, K_JUMP, K_BREAK, K_MATCHKW, K_LET,
         K_DECL, K_THIS, K_CALL, K_TRUE, K_FALSE, K_NULL, K_RETURN } };

   function automatic logic [5:0] kw_kind(input logic lang,
                                          input logic [8*KW_BYTES-1:0] text,
                                          input logic [15:0] len);
      logic [5:0]            kind;
      logic [8*KW_BYTES-1:0] mask;
      kind = K_NAME;
      if (len <= 16'(KW_BYTES)) begin
         for (int i = 0; i < KW_COUNT; i++) begin
            mask = ~({(8*KW_BYTES){1'b1}} >> {KW_LEN[lang][i], 3'b000});
            if (16'(KW_LEN[lang][i]) == len && ((text ^ KW_TEXT[lang][i]) & mask) == '0) begin
               kind = KW_KIND[lang][i];
            end
         end
      end
      return kind;
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic logic is_num(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_op(input logic [7:0] b);
      return b == "+" || b == "-" || b == "*" || b == "/" || b == "^" || b == "%" ||
             b == "=" || b == "<" || b == ">" || b == "&" || b == "|" || b == "?" ||
             b == "~";
   endfunction

   function automatic logic [5:0] op_alone(input logic [7:0] op);
      logic [5:0] k;
      unique case (op)
         "+":     k = K_ADD;
         "-":     k = K_SUB;
         "*":     k = K_MUL;
         "/":     k = K_DIV;
         "^":     k = K_POW;
         "%":     k = K_MOD;
         "=":     k = K_ASSIGN;
         "<":     k = K_LT;
         ">":     k = K_GT;
         "&":     k = K_AND;
         "|":     k = K_OR;
         "?":     k = K_QUERY;
         default: k = K_NOT;
      endcase
      return k;
   endfunction

   // two-byte operator; OP_TWICE marks << and >> that may take a third byte
   function automatic logic [7:0] op_pair(input logic [7:0] op, input logic [7:0] b);
      logic [7:0] k;
      k = OP_NONE;
      unique case (op)
         "+": if (b == "=") k = {2'b00, K_ADD_SET}; else if (b == "+") k = {2'b00, K_INC};
         "-": if (b == "=") k = {2'b00, K_SUB_SET}; else if (b == "-") k = {2'b00, K_DECR};
              else if (b == ">") k = {2'b00, K_ARROW};
         "*": if (b == "=") k = {2'b00, K_MUL_SET};
         "/": if (b == "=") k = {2'b00, K_DIV_SET};
         "^": if (b == "=") k = {2'b00, K_POW_SET};
         "%": if (b == "=") k = {2'b00, K_MOD_SET};
         "~": if (b == "=") k = {2'b00, K_NOT_SET};
         "=": if (b == "=") k = {2'b00, K_EQ}; else if (b == ">") k = {2'b00, K_FAT};
         "<": if (b == "=") k = {2'b00, K_LE}; else if (b == "<") k = OP_TWICE;
         ">": if (b == "=") k = {2'b00, K_GE}; else if (b == ">") k = OP_TWICE;
         "&": if (b == "&") k = {2'b00, K_LAND}; else if (b == "=") k = {2'b00, K_AND_SET};
         "|": if (b == "|") k = {2'b00, K_LOR}; else if (b == "=") k = {2'b00, K_OR_SET};
         "?": if (b == "!") k = {2'b00, K_COALESCE};
         default: k = OP_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] esc_value(input logic [7:0] b, input logic single);
      logic [7:0] v;
      case (b)
         "n":     v = 8'h0A;
         "r":     v = 8'h0D;
         "f":     v = 8'h0C;
         "t":     v = 8'h09;
         "v":     v = 8'h0B;
         "a":     v = 8'h07;
         "b":     v = 8'h08;
         "\\":    v = "\\";
         "\"":    v = single ? 8'h00 : "\"";
         "'":     v = single ? "'" : 8'h00;
         "#":     v = single ? "#" : 8'h00;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic result_type mk_res(input logic item, input logic [5:0] kind,
                                         input logic [23:0] ln, input logic [15:0] col,
                                         input logic [15:0] len, input logic [62:0] val,
                                         input logic [7:0] sb);
      result_type r;
      r.item_kind     = item;
      r.token_kind    = kind;
      r.line_number   = ln;
      r.column_number = col;
      r.token_length  = len;
      r.integer_value = val;
      r.string_byte   = sb;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sts_if.sv =====
// handshake channels of the script token scanner: text bytes in, results out,
// keyword language register write; payload fields are declared as plain logic
`default_nettype none

interface sts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

interface sts_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [5:0]  token_kind;
   logic [23:0] line_number;
   logic [15:0] column_number;
   logic [15:0] token_length;
   logic [62:0] integer_value;
   logic [7:0]  string_byte;
   logic        last_of_run;
   modport source (output valid, output item_kind, output token_kind, output line_number,
                   output column_number, output token_length, output integer_value,
                   output string_byte, output last_of_run, input ready);
   modport sink (input valid, input item_kind, input token_kind, input line_number,
                 input column_number, input token_length, input integer_value,
                 input string_byte, input last_of_run, output ready);
endinterface

interface sts_csr_if;
   logic valid;
   logic ready;
   logic keyword_language;
   modport source (output valid, output keyword_language, input ready);
   modport sink (input valid, input keyword_language, output ready);
endinterface

`default_nettype wire

// ===== rtl/sts_front.sv =====
// front end of the scanner: takes one text byte a beat, runs the lexer state
// and builds the bundle of results it causes; uses sts_pkg and sts_if
`default_nettype none

module sts_front
   import sts_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   sts_req_if.sink     req_if,
   sts_csr_if.sink     csr_if,
   output logic        push_valid,
   output bundle_type  push_data,
   input  wire logic   push_ready
);

   logic [3:0]                   mode_ff, mode_in;
   logic [23:0]                  line_ff, line_in;
   logic [15:0]                  col_ff, col_in;
   logic [15:0]                  cnt_ff, cnt_in;
   logic [62:0]                  acc_ff, acc_in;
   logic [LVL_W-1:0]             lvl_ff, lvl_in;
   logic [7:0]                   op_ff, op_in;
   logic [0:KW_BYTES-1][7:0]     wp_ff, wp_in;
   logic [NEST_DEPTH-1:0][7:0]   bd_ff, bd_in;
   logic                         lang_ff;
   logic                         accept;
   bundle_type                   bundle;

   assign req_if.ready = push_ready;
   assign csr_if.ready = 1'b1;
   assign accept       = req_if.valid && push_ready;
   assign push_valid   = accept && (bundle.count != 2'd0);
   assign push_data    = bundle;

   always_comb begin
      logic [3:0]                 m;
      logic [23:0]                ln;
      logic [15:0]                col;
      logic [15:0]                cnt;
      logic [62:0]                acc;
      logic [LVL_W-1:0]           lvl;
      logic [7:0]                 op;
      logic [0:KW_BYTES-1][7:0]   wp;
      logic [NEST_DEPTH-1:0][7:0] bd;
      logic [1:0]                 n;
      result_type [MAX_RES-1:0]   res;
      logic                       rescan;
      logic                       do_begin;
      logic                       do_str;
      logic                       sgl;
      logic [7:0]                 b;
      logic [7:0]                 k;
      logic [66:0]                t;
      logic [IDX_W-1:0]           top;

      m = mode_ff; ln = line_ff; col = col_ff; cnt = cnt_ff; acc = acc_ff;
      lvl = lvl_ff; op = op_ff; wp = wp_ff; bd = bd_ff;
      n = 2'd0; res = '0; rescan = 1'b0; do_begin = 1'b0; do_str = 1'b0;
      sgl = 1'b0; b = req_if.text_byte; k = OP_NONE; t = '0;
      top = IDX_W'(lvl - LVL_W'(1));

      if (b == 8'h00) begin
         // end of text: flush what is pending, then the end token
         unique case (m) inside
            M_OP: begin
               res[n] = mk_res(ITEM_TOKEN, op_alone(op), ln, col, cnt, '0, 8'h00); n++;
            end
            M_OP2: begin
               res[n] = mk_res(ITEM_TOKEN, (op == "<") ? K_SHL : K_SHR, ln, col, cnt, '0,
                               8'h00); n++;
            end
            M_WORD: begin
               res[n] = mk_res(ITEM_TOKEN, kw_kind(lang_ff, wp, cnt), ln, col, cnt, '0,
                               8'h00); n++;
            end
            M_INT: begin
               res[n] = mk_res(ITEM_TOKEN, K_INT, ln, col, cnt, acc, 8'h00); n++;
            end
            M_REAL: begin
               res[n] = mk_res(ITEM_TOKEN, K_REAL, ln, col, cnt, '0, 8'h00); n++;
            end
            M_SQ_HASH: begin
               res[n] = mk_res(ITEM_BYTE, K_END, ln, col, '0, '0, "#"); n++;
               res[n] = mk_res(ITEM_TOKEN, K_END, ln, col, cnt, '0, 8'h00); n++;
            end
            M_DQ, M_DQ_ESC, M_SQ, M_SQ_ESC: begin
               res[n] = mk_res(ITEM_TOKEN, K_END, ln, col, cnt, '0, 8'h00); n++;
            end
            default: ;
         endcase
         res[n] = mk_res(ITEM_TOKEN, K_END, ln, col, '0, '0, 8'h00); n++;
         m = M_IDLE; ln = 24'd1; col = '0; cnt = '0; acc = '0; lvl = '0; op = 8'h00;
      end else begin
         unique case (m) inside
            M_COMMENT: begin
               if (b == "\n") begin
                  m = M_IDLE; rescan = 1'b1;
               end else if (col != U16_MAX) col++;
            end
            M_OP: begin
               k = op_pair(op, b);
               if (k == OP_NONE) begin
                  res[n] = mk_res(ITEM_TOKEN, op_alone(op), ln, col, cnt, '0, 8'h00); n++;
                  m = M_IDLE; rescan = 1'b1;
               end else begin
                  if (cnt != U16_MAX) cnt++;
                  if (col != U16_MAX) col++;
                  if (k == OP_TWICE) m = M_OP2;
                  else begin
                     res[n] = mk_res(ITEM_TOKEN, k[5:0], ln, col, cnt, '0, 8'h00); n++;
                     m = M_IDLE;
                  end
               end
            end
            M_OP2: begin
               m = M_IDLE;
               if (b == "=") begin
                  if (cnt != U16_MAX) cnt++;
                  if (col != U16_MAX) col++;
                  res[n] = mk_res(ITEM_TOKEN, (op == "<") ? K_SHL_SET : K_SHR_SET, ln, col,
                                  cnt, '0, 8'h00); n++;
               end else begin
                  res[n] = mk_res(ITEM_TOKEN, (op == "<") ? K_SHL : K_SHR, ln, col, cnt,
                                  '0, 8'h00); n++;
                  rescan = 1'b1;
               end
            end
            M_WORD: begin
               if (is_letter(b) || is_num(b)) begin
                  if (cnt < 16'(KW_BYTES)) wp[cnt[KW_IDX_W-1:0]] = b;
                  if (cnt != U16_MAX) cnt++;
                  if (col != U16_MAX) col++;
               end else begin
                  res[n] = mk_res(ITEM_TOKEN, kw_kind(lang_ff, wp, cnt), ln, col, cnt, '0,
                                  8'h00); n++;
                  m = M_IDLE; rescan = 1'b1;
               end
            end
            M_INT: begin
               if (is_num(b)) begin
                  // acc * 10 + digit, saturated
                  t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {63'd0, b[3:0]};
                  acc = (t > {4'd0, INT_MAX}) ? INT_MAX : t[62:0];
                  if (cnt != U16_MAX) cnt++;
                  if (col != U16_MAX) col++;
               end else if (b == ".") begin
                  if (cnt != U16_MAX) cnt++;
                  if (col != U16_MAX) col++;
                  m = M_REAL;
               end else begin
                  res[n] = mk_res(ITEM_TOKEN, K_INT, ln, col, cnt, acc, 8'h00); n++;
                  m = M_IDLE; rescan = 1'b1;
               end
            end
            M_REAL: begin
               if (is_num(b)) begin
                  if (cnt != U16_MAX) cnt++;
                  if (col != U16_MAX) col++;
               end else begin
                  res[n] = mk_res(ITEM_TOKEN, K_REAL, ln, col, cnt, '0, 8'h00); n++;
                  m = M_IDLE; rescan = 1'b1;
               end
            end
            M_DQ, M_SQ: begin
               do_str = 1'b1; sgl = (m == M_SQ);
            end
            M_DQ_ESC, M_SQ_ESC: begin
               sgl = (m == M_SQ_ESC);
               if (cnt != U16_MAX) cnt++;
               if (b == "\n") begin
                  if (ln != LINE_MAX) ln++;
                  col = '0;
               end else begin
                  res[n] = mk_res(ITEM_BYTE, K_END, ln, col, '0, '0, esc_value(b, sgl)); n++;
               end
               m = sgl ? M_SQ : M_DQ;
            end
            M_SQ_HASH: begin
               if (b == "{") begin
                  if (cnt != U16_MAX) cnt++;
                  if (col != U16_MAX) col++;
                  if (lvl < LVL_W'(NEST_DEPTH)) begin
                     bd[IDX_W'(lvl)] = 8'd1;
                     lvl++;
                  end
                  res[n] = mk_res(ITEM_TOKEN, K_STR, ln, col, cnt, '0, "{"); n++;
                  m = M_IDLE;
               end else begin
                  res[n] = mk_res(ITEM_BYTE, K_END, ln, col, '0, '0, "#"); n++;
                  m = M_SQ; rescan = 1'b1;
               end
            end
            default: begin
               m = M_IDLE; do_begin = 1'b1;
            end
         endcase

         // second look at the same byte in the mode the first pass left
         if (rescan) begin
            if (m == M_SQ) begin
               do_str = 1'b1; sgl = 1'b1;
            end else do_begin = 1'b1;
         end

         if (do_str) begin
            if (cnt != U16_MAX) cnt++;
            if (b == (sgl ? "'" : "\"")) begin
               res[n] = mk_res(ITEM_TOKEN, K_STR, ln, col, cnt, '0, b); n++;
               m = M_IDLE;
            end else if (b == "\\") begin
               m = sgl ? M_SQ_ESC : M_DQ_ESC;
            end else if (sgl && b == "#") begin
               m = M_SQ_HASH;
            end else begin
               if (b == "\n") begin
                  if (ln != LINE_MAX) ln++;
                  col = '0;
               end
               res[n] = mk_res(ITEM_BYTE, K_END, ln, col, '0, '0, b); n++;
            end
         end

         if (do_begin) begin
            if (b == " " || b == "\t") begin
               if (col != U16_MAX) col++;
            end else if (b == ";") begin
               if (col != U16_MAX) col++;
               m = M_COMMENT;
            end else begin
               cnt = 16'd1;
               if (col != U16_MAX) col++;
               if (is_op(b)) begin
                  op = b; m = M_OP;
               end else if (b == "\n") begin
                  if (ln != LINE_MAX) ln++;
                  col = '0;
                  res[n] = mk_res(ITEM_TOKEN, K_NEWLINE, ln, col, cnt, '0, 8'h00); n++;
               end else if (b == "(") begin
                  res[n] = mk_res(ITEM_TOKEN, K_LPAR, ln, col, cnt, '0, 8'h00); n++;
               end else if (b == ")") begin
                  res[n] = mk_res(ITEM_TOKEN, K_RPAR, ln, col, cnt, '0, 8'h00); n++;
               end else if (b == "[") begin
                  res[n] = mk_res(ITEM_TOKEN, K_LCURLY, ln, col, cnt, '0, 8'h00); n++;
               end else if (b == "]") begin
                  res[n] = mk_res(ITEM_TOKEN, K_RSQUARE, ln, col, cnt, '0, 8'h00); n++;
               end else if (b == ":") begin
                  res[n] = mk_res(ITEM_TOKEN, K_COLON, ln, col, cnt, '0, 8'h00); n++;
               end else if (b == ",") begin
                  res[n] = mk_res(ITEM_TOKEN, K_COMMA, ln, col, cnt, '0, 8'h00); n++;
               end else if (b == "{") begin
                  if (lvl != '0) bd[top] = bd[top] + 8'd1;
                  res[n] = mk_res(ITEM_TOKEN, K_LCURLY, ln, col, cnt, '0, 8'h00); n++;
               end else if (b == "}") begin
                  // closing the interpolation resumes the single-quoted string
                  if (lvl != '0 && bd[top] == 8'd1) begin
                     bd[top] = 8'd0;
                     lvl--;
                     m = M_SQ;
                  end else begin
                     if (lvl != '0) bd[top] = bd[top] - 8'd1;
                     res[n] = mk_res(ITEM_TOKEN, K_RCURLY, ln, col, cnt, '0, 8'h00); n++;
                  end
               end else if (b == "\"") begin
                  m = M_DQ;
               end else if (b == "'") begin
                  m = M_SQ;
               end else if (is_letter(b)) begin
                  wp[0] = b; m = M_WORD;
               end else if (is_num(b)) begin
                  acc = {59'd0, b[3:0]}; m = M_INT;
               end else begin
                  res[n] = mk_res(ITEM_TOKEN, K_END, ln, col, cnt, '0, 8'h00); n++;
               end
            end
         end
      end

      mode_in = m; line_in = ln; col_in = col; cnt_in = cnt; acc_in = acc;
      lvl_in = lvl; op_in = op; wp_in = wp; bd_in = bd;
      bundle.count = n;
      bundle.res   = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         line_ff <= 24'd1;
         col_ff  <= '0;
         cnt_ff  <= '0;
         acc_ff  <= '0;
         lvl_ff  <= '0;
         op_ff   <= 8'h00;
         lang_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            line_ff <= line_in;
            col_ff  <= col_in;
            cnt_ff  <= cnt_in;
            acc_ff  <= acc_in;
            lvl_ff  <= lvl_in;
            op_ff   <= op_in;
         end
         if (csr_if.valid) lang_ff <= csr_if.keyword_language;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wp_ff <= wp_in;
         bd_ff <= bd_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sts_queue.sv =====
// two-entry bundle queue between the scanner front and the output side;
// uses bundle_type from sts_pkg
`default_nettype none

module sts_queue
   import sts_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   input  bundle_type     push_data,
   output logic           push_ready,
   output logic           pop_valid,
   output bundle_type     pop_data,
   input  wire logic      pop_ready,
   output queue_stat_type stat
);

   bundle_type mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);

   always_comb begin
      wr_in    = do_push ? ~wr_ff : wr_ff;
      rd_in    = do_pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// ===== rtl/sts_back.sv =====
// output side: holds one bundle in a register and hands its results out one
// beat at a time; uses sts_pkg and sts_rsp_if
`default_nettype none

module sts_back
   import sts_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  pop_valid,
   input  bundle_type pop_data,
   output logic       pop_ready,
   sts_rsp_if.source  rsp_if
);

   bundle_type cur_ff;
   logic       cur_valid_ff;
   logic [1:0] idx_ff;
   logic       last;
   logic       load;
   result_type r;

   assign last      = (idx_ff == cur_ff.count - 2'd1);
   assign load      = !cur_valid_ff || (rsp_if.ready && last);
   assign pop_ready = load;
   assign r         = cur_ff.res[idx_ff];

   assign rsp_if.valid         = cur_valid_ff;
   assign rsp_if.item_kind     = r.item_kind;
   assign rsp_if.token_kind    = r.token_kind;
   assign rsp_if.line_number   = r.line_number;
   assign rsp_if.column_number = r.column_number;
   assign rsp_if.token_length  = r.token_length;
   assign rsp_if.integer_value = r.integer_value;
   assign rsp_if.string_byte   = r.string_byte;
   assign rsp_if.last_of_run   = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (load) begin
         cur_valid_ff <= pop_valid;
         idx_ff       <= 2'd0;
      end else if (rsp_if.ready) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) cur_ff <= pop_data;
   end

endmodule

`default_nettype wire

// ===== rtl/script_token_scanner.sv =====
// Script token scanner: takes one source byte per beat and returns tokens and
// decoded string bytes; a byte is taken every cycle while the two-entry result
// queue has room, and each byte's results (up to three) leave the output register
// one per cycle while the receiver is ready; the sustained rate is one byte per
// cycle when bytes cause at most one result each, else set by the output beats.
// A zero byte ends the text and resets all scanner state but the keyword language.
`default_nettype none

module script_token_scanner
   import sts_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   sts_req_if.sink   req_if,
   sts_csr_if.sink   csr_if,
   sts_rsp_if.source rsp_if
);

   logic           push_valid, push_ready;
   bundle_type     push_data;
   logic           pop_valid, pop_ready;
   bundle_type     pop_data;
   queue_stat_type q_stat;

   sts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_if     (csr_if),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   sts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready),
      .stat       (q_stat)
   );

   sts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

`ifndef SYNTHESIS
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("result valid right after reset");
   a_queue_stat: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue full and empty at once");
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && !rsp_if.last_of_run) |=> rsp_if.valid)
      else $error("result run broken off");
   a_byte_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.item_kind == ITEM_BYTE) |-> rsp_if.token_kind == K_END)
      else $error("string byte carries a token kind");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for script_token_scanner: drives text bytes and
// keyword language writes, predicts every result beat; needs sts_pkg, sts_if
`default_nettype none

module testbench;
   import sts_pkg::*;

   localparam logic [7:0] NO_PAIR    = 8'd255;
   localparam logic [7:0] SHIFT_PAIR = 8'd254;

   typedef struct {
      result_type r;
      bit         last;
   } scan_out_type;

   logic clock;
   logic reset;

   sts_req_if req_bus();
   sts_rsp_if rsp_bus();
   sts_csr_if csr_bus();

   script_token_scanner uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .csr_if (csr_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // scanner shadow state
   bit          lang;
   logic [3:0]  mode;
   logic [23:0] line_no;
   logic [15:0] col_no;
   logic [15:0] tok_len;
   logic [7:0]  prefix [8];
   logic [62:0] accum;
   logic [7:0]  depth [8];
   int          level;
   logic [7:0]  pend_op;
   result_type  step_out [3];
   int          step_cnt;

   scan_out_type expected_beats [$];
   byte         text_q [$];
   int          errors;
   int          bytes_taken;
   bit          req_busy;
   int          req_gap;
   int          rsp_hold;
   int          idle_style;
   bit          choke;

   function automatic int draw_gap();
      case (idle_style)
         0: return 0;
         1: return $urandom_range(0, 18);
         default: return ($urandom_range(0, 6) == 0) ? $urandom_range(1, 18) : 0;
      endcase
   endfunction

   function automatic bit letter_byte(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic bit digit_byte(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic void emit(logic item, logic [5:0] kind, logic [15:0] len,
                                logic [62:0] val, logic [7:0] sb);
      if (step_cnt < 3) begin
         step_out[step_cnt].item_kind     = item;
         step_out[step_cnt].token_kind    = kind;
         step_out[step_cnt].line_number   = line_no;
         step_out[step_cnt].column_number = col_no;
         step_out[step_cnt].token_length  = len;
         step_out[step_cnt].integer_value = val;
         step_out[step_cnt].string_byte   = sb;
         step_cnt++;
      end
   endfunction

   function automatic void emit_tok(logic [5:0] kind);
      emit(ITEM_TOKEN, kind, tok_len, '0, 8'd0);
   endfunction

   function automatic void col_up();
      if (col_no != 16'hFFFF) col_no++;
   endfunction

   function automatic void len_up();
      if (tok_len != 16'hFFFF) tok_len++;
   endfunction

   function automatic void next_line();
      if (line_no != 24'hFFFFFF) line_no++;
      col_no = 0;
   endfunction

   task automatic clear_scanner();
      mode = M_IDLE;
      line_no = 1;
      col_no = 0;
      tok_len = 0;
      accum = 0;
      level = 0;
      pend_op = 0;
      for (int i = 0; i < 8; i++) begin
         prefix[i] = 0;
         depth[i] = 0;
      end
   endtask

   function automatic logic [5:0] word_class();
      string s;
      s = "";
      if (tok_len > 8) return K_NAME;
      for (int i = 0; i < tok_len; i++) s = {s, string'(prefix[i])};
      if (!lang) begin
         case (s)
            "if": return K_IF;       "let": return K_LET;     "dec": return K_DECL;
            "else": return K_ELSE;   "this": return K_THIS;   "true": return K_TRUE;
            "false": return K_FALSE; "null": return K_NULL;   "for": return K_FOR;
            "call": return K_CALL;   "jump": return K_JUMP;   "break": return K_BREAK;
            "while": return K_WHILE; "match": return K_MATCHKW;
            "return": return K_RETURN;
            default: return K_NAME;
         endcase
      end
      case (s)
         "si": return K_IF;          "sino": return K_ELSE;     "por": return K_FOR;
         "mientras": return K_WHILE; "salta": return K_JUMP;    "sale": return K_BREAK;
         "coincide": return K_MATCHKW; "deja": return K_LET;    "dec": return K_DECL;
         "esto": return K_THIS;      "llama": return K_CALL;    "verdad": return K_TRUE;
         "falso": return K_FALSE;    "nulo": return K_NULL;     "regresa": return K_RETURN;
         default: return K_NAME;
      endcase
   endfunction

   function automatic logic [5:0] single_op(logic [7:0] op);
      case (op)
         "+": return K_ADD;    "-": return K_SUB;   "*": return K_MUL;
         "/": return K_DIV;    "^": return K_POW;   "%": return K_MOD;
         "=": return K_ASSIGN; "<": return K_LT;    ">": return K_GT;
         "&": return K_AND;    "|": return K_OR;    "?": return K_QUERY;
         default: return K_NOT;
      endcase
   endfunction

   function automatic logic [7:0] double_op(logic [7:0] op, logic [7:0] b);
      case (op)
         "+": if (b == "=") return K_ADD_SET; else if (b == "+") return K_INC;
         "-": if (b == "=") return K_SUB_SET; else if (b == "-") return K_DECR;
              else if (b == ">") return K_ARROW;
         "*": if (b == "=") return K_MUL_SET;
         "/": if (b == "=") return K_DIV_SET;
         "^": if (b == "=") return K_POW_SET;
         "%": if (b == "=") return K_MOD_SET;
         "~": if (b == "=") return K_NOT_SET;
         "=": if (b == "=") return K_EQ; else if (b == ">") return K_FAT;
         "<": if (b == "=") return K_LE; else if (b == "<") return SHIFT_PAIR;
         ">": if (b == "=") return K_GE; else if (b == ">") return SHIFT_PAIR;
         "&": if (b == "&") return K_LAND; else if (b == "=") return K_AND_SET;
         "|": if (b == "|") return K_LOR; else if (b == "=") return K_OR_SET;
         "?": if (b == "!") return K_COALESCE;
         default: ;
      endcase
      return NO_PAIR;
   endfunction

   function automatic logic [7:0] unescape(logic [7:0] b, bit single);
      case (b)
         "n": return 8'h0A;  "r": return 8'h0D;  "f": return 8'h0C;
         "t": return 8'h09;  "v": return 8'h0B;  "a": return 8'h07;
         "b": return 8'h08;  "\\": return "\\";
         "\"": return single ? 8'h00 : "\"";
         "'": return single ? "'" : 8'h00;
         "#": return single ? "#" : 8'h00;
         default: return 8'h00;
      endcase
   endfunction

   function automatic void start_token(logic [7:0] b);
      if (b == " " || b == "\t") begin
         col_up();
         return;
      end
      if (b == ";") begin
         col_up();
         mode = M_COMMENT;
         return;
      end
      tok_len = 1;
      col_up();
      case (b)
         "+", "-", "*", "/", "^", "%", "=", "<", ">", "&", "|", "?", "~": begin
            pend_op = b;
            mode = M_OP;
         end
         "\n": begin
            next_line();
            emit_tok(K_NEWLINE);
         end
         "(": emit_tok(K_LPAR);
         ")": emit_tok(K_RPAR);
         "[": emit_tok(K_LCURLY);
         "]": emit_tok(K_RSQUARE);
         ":": emit_tok(K_COLON);
         ",": emit_tok(K_COMMA);
         "{": begin
            if (level > 0) depth[level-1]++;
            emit_tok(K_LCURLY);
         end
         "}": begin
            if (level > 0) begin
               depth[level-1]--;
               if (depth[level-1] == 0) begin
                  // closing brace of an interpolation resumes the string
                  level--;
                  mode = M_SQ;
                  return;
               end
            end
            emit_tok(K_RCURLY);
         end
         "\"": mode = M_DQ;
         "'": mode = M_SQ;
         default: begin
            if (letter_byte(b)) begin
               prefix[0] = b;
               mode = M_WORD;
            end else if (digit_byte(b)) begin
               accum = 63'(b - "0");
               mode = M_INT;
            end else begin
               emit_tok(K_END);
            end
         end
      endcase
   endfunction

   // returns 1 when the byte has to be scanned again
   function automatic bit scan_byte(logic [7:0] b);
      logic [7:0]  k;
      logic [62:0] d;
      bit          single;
      single = (mode == M_SQ || mode == M_SQ_ESC);
      case (mode)
         M_COMMENT: begin
            if (b == "\n") begin
               mode = M_IDLE;
               return 1;
            end
            col_up();
            return 0;
         end
         M_OP: begin
            k = double_op(pend_op, b);
            if (k == NO_PAIR) begin
               emit_tok(single_op(pend_op));
               mode = M_IDLE;
               return 1;
            end
            len_up();
            col_up();
            if (k == SHIFT_PAIR) begin
               mode = M_OP2;
               return 0;
            end
            emit_tok(k[5:0]);
            mode = M_IDLE;
            return 0;
         end
         M_OP2: begin
            mode = M_IDLE;
            if (b == "=") begin
               len_up();
               col_up();
               emit_tok(pend_op == "<" ? K_SHL_SET : K_SHR_SET);
               return 0;
            end
            emit_tok(pend_op == "<" ? K_SHL : K_SHR);
            return 1;
         end
         M_WORD: begin
            if (letter_byte(b) || digit_byte(b)) begin
               if (tok_len < 8) prefix[tok_len] = b;
               len_up();
               col_up();
               return 0;
            end
            emit_tok(word_class());
            mode = M_IDLE;
            return 1;
         end
         M_INT: begin
            if (digit_byte(b)) begin
               d = 63'(b - "0");
               if (accum > (INT_MAX - d) / 10) accum = INT_MAX;
               else accum = accum * 10 + d;
               len_up();
               col_up();
               return 0;
            end
            if (b == ".") begin
               len_up();
               col_up();
               mode = M_REAL;
               return 0;
            end
            emit(ITEM_TOKEN, K_INT, tok_len, accum, 8'd0);
            mode = M_IDLE;
            return 1;
         end
         M_REAL: begin
            if (digit_byte(b)) begin
               len_up();
               col_up();
               return 0;
            end
            emit_tok(K_REAL);
            mode = M_IDLE;
            return 1;
         end
         M_DQ, M_SQ: begin
            len_up();
            if (b == (single ? "'" : "\"")) begin
               emit(ITEM_TOKEN, K_STR, tok_len, '0, b);
               mode = M_IDLE;
            end else if (b == "\\") begin
               mode = single ? M_SQ_ESC : M_DQ_ESC;
            end else if (single && b == "#") begin
               mode = M_SQ_HASH;
            end else begin
               if (b == "\n") next_line();
               emit(ITEM_BYTE, K_END, 16'd0, '0, b);
            end
            return 0;
         end
         M_DQ_ESC, M_SQ_ESC: begin
            len_up();
            if (b == "\n") next_line();
            else emit(ITEM_BYTE, K_END, 16'd0, '0, unescape(b, single));
            mode = single ? M_SQ : M_DQ;
            return 0;
         end
         M_SQ_HASH: begin
            if (b == "{") begin
               len_up();
               col_up();
               if (level < NEST_DEPTH) begin
                  depth[level] = 1;
                  level++;
               end
               emit(ITEM_TOKEN, K_STR, tok_len, '0, "{");
               mode = M_IDLE;
               return 0;
            end
            emit(ITEM_BYTE, K_END, 16'd0, '0, "#");
            mode = M_SQ;
            return 1;
         end
         default: begin
            mode = M_IDLE;
            start_token(b);
            return 0;
         end
      endcase
   endfunction

   task automatic end_of_text();
      case (mode)
         M_OP: emit_tok(single_op(pend_op));
         M_OP2: emit_tok(pend_op == "<" ? K_SHL : K_SHR);
         M_WORD: emit_tok(word_class());
         M_INT: emit(ITEM_TOKEN, K_INT, tok_len, accum, 8'd0);
         M_REAL: emit_tok(K_REAL);
         M_SQ_HASH: begin
            emit(ITEM_BYTE, K_END, 16'd0, '0, "#");
            emit_tok(K_END);
         end
         M_DQ, M_DQ_ESC, M_SQ, M_SQ_ESC: emit_tok(K_END);
         default: ;
      endcase
      emit(ITEM_TOKEN, K_END, 16'd0, '0, 8'd0);
      clear_scanner();
   endtask

   task automatic predict_byte(logic [7:0] b);
      scan_out_type e;
      step_cnt = 0;
      if (b == 0) end_of_text();
      else if (scan_byte(b)) void'(scan_byte(b));
      for (int i = 0; i < step_cnt; i++) begin
         e.r = step_out[i];
         e.last = (i == step_cnt - 1);
         expected_beats.push_back(e);
      end
   endtask

   task automatic report(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   // accepted text bytes feed the predictor, result beats are checked
   always @(posedge clock) begin
      scan_out_type e;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) lang = csr_bus.keyword_language;
         if (req_bus.valid && req_bus.ready) begin
            predict_byte(req_bus.text_byte);
            req_busy = 0;
            bytes_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_hold = draw_gap();
            if (expected_beats.size() == 0) begin
               report("unexpected beat, token_kind", rsp_bus.token_kind, 0);
            end else begin
               e = expected_beats.pop_front();
               if (rsp_bus.item_kind !== e.r.item_kind)
                  report("item_kind", rsp_bus.item_kind, e.r.item_kind);
               if (rsp_bus.token_kind !== e.r.token_kind)
                  report("token_kind", rsp_bus.token_kind, e.r.token_kind);
               if (rsp_bus.line_number !== e.r.line_number)
                  report("line_number", rsp_bus.line_number, e.r.line_number);
               if (rsp_bus.column_number !== e.r.column_number)
                  report("column_number", rsp_bus.column_number, e.r.column_number);
               if (rsp_bus.token_length !== e.r.token_length)
                  report("token_length", rsp_bus.token_length, e.r.token_length);
               if (rsp_bus.integer_value !== e.r.integer_value)
                  report("integer_value", rsp_bus.integer_value, e.r.integer_value);
               if (rsp_bus.string_byte !== e.r.string_byte)
                  report("string_byte", rsp_bus.string_byte, e.r.string_byte);
               if (rsp_bus.last_of_run !== e.last)
                  report("last_of_run", rsp_bus.last_of_run, e.last);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && !req_busy) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (text_q.size() > 0) begin
            req_bus.text_byte <= text_q.pop_front();
            req_bus.valid <= 1'b1;
            req_busy = 1;
            req_gap = draw_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !choke;
         end
      end
   end

   // long result stall while bytes keep coming, so the block backs up
   initial begin
      choke = 0;
      while (bytes_taken < 150) @(posedge clock);
      choke = 1;
      repeat (160) @(posedge clock);
      choke = 0;
   end

   initial begin
      #6000000;
      $display("testbench: errors");
      $finish;
   end

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   function automatic string pick_char(string set);
      return string'(set[$urandom_range(0, set.len() - 1)]);
   endfunction

   function automatic string string_body(bit single);
      string s;
      int    n;
      s = "";
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: s = {s, "\\", pick_char(single ? "nrftvab\\'#q\n" : "nrftvab\\\"#q\n")};
            1: s = {s, "\n"};
            2: s = {s, "#x"};
            default: s = {s, pick_char("abcXYZ 019{}[]+;")};
         endcase
      end
      return s;
   endfunction

   function automatic string fragment();
      string s;
      string words [$];
      string ops [$];
      int    n;
      words = '{"if", "let", "dec", "else", "this", "true", "false", "null", "for", "call",
                "jump", "break", "while", "match", "return", "si", "sino", "por",
                "mientras", "salta", "sale", "coincide", "deja", "esto", "llama",
                "verdad", "falso", "nulo", "regresa", "mientrasx", "iff", "retur"};
      ops = '{"+=", "++", "+", "-=", "--", "->", "-", "*=", "*", "/=", "/", "^=", "^",
              "%=", "%", "~=", "~", "==", "=>", "=", "<=", "<<=", "<<", "<", ">=",
              ">>=", ">>", ">", "&&", "&=", "&", "||", "|=", "|", "?!", "?"};
      s = "";
      case ($urandom_range(0, 12))
         0, 1: s = words[$urandom_range(0, words.size() - 1)];
         2: begin
            s = pick_char("abzAZ_");
            n = $urandom_range(0, 11);
            for (int i = 0; i < n; i++) s = {s, pick_char("abcdefghijklmnopqrstuvwxyzQ_09")};
         end
         3: begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 4);
            for (int i = 0; i < n; i++) s = {s, pick_char("0123456789")};
            if ($urandom_range(0, 3) == 0) s = {s, ".", pick_char("0123456789x")};
         end
         4, 5: s = ops[$urandom_range(0, ops.size() - 1)];
         6: s = pick_char("()[]{}:, \t\n");
         7: s = {";", string_body(0), "\n"};
         8: s = {"\"", string_body(0), "\""};
         9: s = {"'", string_body(1), "#{", pick_char("ab1{["), " ", pick_char("}]"), "}",
                 string_body(1), "'"};
         10: begin
            // nested interpolations, at times one level more than the interpolation stack holds
            n = ($urandom_range(0, 2) == 0) ? 9 : 2;
            for (int i = 0; i < n; i++) s = {s, "'#{"};
            for (int i = 0; i < n; i++) s = {s, "}'"};
         end
         default: s = string'(8'($urandom_range(1, 255)));
      endcase
      return s;
   endfunction

   task automatic write_lang(bit v);
      @(negedge clock);
      csr_bus.keyword_language <= v;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic drain();
      while (text_q.size() > 0 || req_busy || expected_beats.size() > 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   initial begin
      string txt;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.text_byte = 8'd0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.keyword_language = 1'b0;
      errors = 0;
      bytes_taken = 0;
      req_busy = 0;
      req_gap = 0;
      rsp_hold = 0;
      idle_style = 0;
      lang = 0;
      clear_scanner();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // short directed texts, the last one with an unterminated string
      add_text("if a<<=9.5 'x#{y}'\n.");
      text_q.push_back(8'd0);
      add_text("\"\\q");
      text_q.push_back(8'd0);
      drain();
      for (int p = 0; p < 4; p++) begin
         write_lang(p[0] ^ 1'b1);
         idle_style = p % 3;
         while (text_q.size() < 75) begin
            for (int f = $urandom_range(2, 8); f > 0; f--) begin
               txt = fragment();
               add_text(txt);
               if ($urandom_range(0, 1) == 0) add_text(" ");
            end
            if ($urandom_range(0, 5) == 0) add_text("'ab#");
            text_q.push_back(8'd0);
         end
         drain();
      end
      if (errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/sts_pkg.sv
rtl/sts_if.sv
rtl/sts_front.sv
rtl/sts_queue.sv
rtl/sts_back.sv
rtl/script_token_scanner.sv
tb/testbench.sv
